@@ rtl/core/signed_decimal_text_cell_writer_macros.svh @@
// assertion macros for the decimal text cell writer
`ifndef SIGNED_DECIMAL_TEXT_CELL_WRITER_MACROS_SVH
`define SIGNED_DECIMAL_TEXT_CELL_WRITER_MACROS_SVH

`ifndef SYNTH
// property must hold on every clock edge outside reset
`define SDTCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define SDTCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDTCW_ASSERT(label, prop, msg)
`define SDTCW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/sdtcw_pkg.sv @@
package sdtcw_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int MAG_W      = 32;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int BIT_CNT_W  = $clog2(MAG_W);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] SCREEN_COLUMNS_RST = 8'd80;
  localparam logic [7:0] SCREEN_ROWS_RST    = 8'd25;
  localparam logic [7:0] ASCII_ZERO         = 8'h30;
  localparam logic [7:0] ASCII_MINUS        = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_COLUMNS,
    CFG_SCREEN_ROWS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLACE,
    ST_DIGIT,
    ST_SIGN,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         attribute;
    logic [7:0]         row;
    logic [7:0]         column;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [7:0]        char_code;
    logic [7:0]        cell_attribute;
    logic              out_of_range;
    logic              last;
  } out_item_t;

endpackage

@@ rtl/core/signed_decimal_text_cell_writer.sv @@
// channel | dir | handshake         | payload
// in_     | in  | in_valid/in_stall  | value, attribute, row, column
// out_    | out | out_valid/out_stall| cell_index, char_code, cell_attribute, out_of_range, last
// cfg_    | in  | cfg_we             | cfg_index selects register, cfg_wdata
//
// one request at a time: the accept cycle, bit-serial double dabble over the 32 magnitude bits
// (one magnitude bit per cycle), a placement state, then one result per cycle while out_stall
// is low, giving n results (1 to 11) per request
// an out-of-range request skips conversion and goes from the accept to its error result
// out_stall holds the output register and freezes emission; the next request can be
// taken while the final result still waits there
// rst_n is synchronous; control and the two screen registers are reset
module signed_decimal_text_cell_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sdtcw_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sdtcw_pkg::out_item_t               out_data,
  input  logic                               cfg_we,
  input  logic [sdtcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdtcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

`include "signed_decimal_text_cell_writer_macros.svh"

  // screen geometry registers; rows is held only, it cancels out of the address
  logic [7:0] cols_r;
  logic [7:0] rows_r;

  sdtcw_pkg::state_t state_r, state_nxt;

  // conversion datapath
  logic [sdtcw_pkg::MAG_W-1:0]     mag_r, mag_nxt;
  logic [sdtcw_pkg::BCD_W-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [sdtcw_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [sdtcw_pkg::DIG_CNT_W-1:0] dig_left_r, dig_left_nxt, ndig;
  logic                            neg_r, neg_nxt;
  logic [7:0]                      attr_r, attr_nxt;
  logic [sdtcw_pkg::CELL_W-1:0]    base_r, base_nxt;
  logic [sdtcw_pkg::CELL_W-1:0]    ptr_r, ptr_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  sdtcw_pkg::out_item_t out_r, out_nxt;

  // request decode
  logic                            in_fire;
  logic                            in_neg;
  logic [sdtcw_pkg::MAG_W-1:0]     in_raw;
  logic [sdtcw_pkg::MAG_W-1:0]     in_mag;
  logic signed [8:0]               cols_s;
  logic signed [9:0]               row_m1;
  logic signed [18:0]              prod;
  logic signed [18:0]              base_full;
  logic signed [18:0]              leftmost;
  logic                            in_err;
  logic                            slot_free;

  assign in_stall  = (state_r != sdtcw_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  // sign and magnitude; the most negative value wraps to its true magnitude
  assign in_raw = in_data.value;
  assign in_neg = in_raw[sdtcw_pkg::MAG_W-1];
  assign in_mag = in_neg ? (~in_raw + 1'b1) : in_raw;

  // base = columns * (row - 1) + column, leftmost cell takes the sign into account
  assign cols_s    = $signed({1'b0, cols_r});
  assign row_m1    = $signed({2'b00, in_data.row}) - 10'sd1;
  assign prod      = cols_s * row_m1;
  assign base_full = prod + $signed({11'b0, in_data.column});
  assign leftmost  = base_full - $signed({18'b0, in_neg});
  assign in_err    = leftmost[18];

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < sdtcw_pkg::MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                    : bcd_r[4*i +: 4];
    end
  end

  // digit count: position of the highest nonzero digit, zero counts as one digit
  always_comb begin
    ndig = sdtcw_pkg::DIG_CNT_W'(1);
    for (int i = 0; i < sdtcw_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        ndig = sdtcw_pkg::DIG_CNT_W'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdtcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = in_err ? sdtcw_pkg::ST_ERROR : sdtcw_pkg::ST_CONV;
        end
      end
      sdtcw_pkg::ST_CONV: begin
        if (bit_cnt_r == sdtcw_pkg::BIT_CNT_W'(sdtcw_pkg::MAG_W - 1)) begin
          state_nxt = sdtcw_pkg::ST_PLACE;
        end
      end
      sdtcw_pkg::ST_PLACE: begin
        state_nxt = sdtcw_pkg::ST_DIGIT;
      end
      sdtcw_pkg::ST_DIGIT: begin
        if (slot_free && dig_left_r == sdtcw_pkg::DIG_CNT_W'(1)) begin
          state_nxt = neg_r ? sdtcw_pkg::ST_SIGN : sdtcw_pkg::ST_IDLE;
        end
      end
      sdtcw_pkg::ST_SIGN: begin
        if (slot_free) begin
          state_nxt = sdtcw_pkg::ST_IDLE;
        end
      end
      sdtcw_pkg::ST_ERROR: begin
        if (slot_free) begin
          state_nxt = sdtcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sdtcw_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and output register
  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_left_nxt  = dig_left_r;
    neg_nxt       = neg_r;
    attr_nxt      = attr_r;
    base_nxt      = base_r;
    ptr_nxt       = ptr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      sdtcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          mag_nxt     = in_mag;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          neg_nxt     = in_neg;
          attr_nxt    = in_data.attribute;
          base_nxt    = base_full[sdtcw_pkg::CELL_W-1:0];
        end
      end
      sdtcw_pkg::ST_CONV: begin
        // shift one magnitude bit into the corrected bcd word
        bcd_nxt     = {bcd_adj[sdtcw_pkg::BCD_W-2:0], mag_r[sdtcw_pkg::MAG_W-1]};
        mag_nxt     = {mag_r[sdtcw_pkg::MAG_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      sdtcw_pkg::ST_PLACE: begin
        // least significant digit lands rightmost
        dig_left_nxt = ndig;
        ptr_nxt      = base_r + sdtcw_pkg::CELL_W'(ndig) - 1'b1;
      end
      sdtcw_pkg::ST_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.cell_index     = ptr_r;
          out_nxt.char_code      = sdtcw_pkg::ASCII_ZERO + {4'b0000, bcd_r[3:0]};
          out_nxt.cell_attribute = attr_r;
          out_nxt.out_of_range   = 1'b0;
          out_nxt.last           = (dig_left_r == sdtcw_pkg::DIG_CNT_W'(1)) && !neg_r;
          bcd_nxt                = {4'b0000, bcd_r[sdtcw_pkg::BCD_W-1:4]};
          ptr_nxt                = ptr_r - 1'b1;
          dig_left_nxt           = dig_left_r - 1'b1;
        end
      end
      sdtcw_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.cell_index     = ptr_r;
          out_nxt.char_code      = sdtcw_pkg::ASCII_MINUS;
          out_nxt.cell_attribute = attr_r;
          out_nxt.out_of_range   = 1'b0;
          out_nxt.last           = 1'b1;
        end
      end
      sdtcw_pkg::ST_ERROR: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.cell_index     = '0;
          out_nxt.char_code      = '0;
          out_nxt.cell_attribute = '0;
          out_nxt.out_of_range   = 1'b1;
          out_nxt.last           = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdtcw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cols_r      <= sdtcw_pkg::SCREEN_COLUMNS_RST;
      rows_r      <= sdtcw_pkg::SCREEN_ROWS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (sdtcw_pkg::cfg_reg_t'(cfg_index))
          sdtcw_pkg::CFG_SCREEN_COLUMNS: cols_r <= cfg_wdata;
          sdtcw_pkg::CFG_SCREEN_ROWS:    rows_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_left_r <= dig_left_nxt;
    neg_r      <= neg_nxt;
    attr_r     <= attr_nxt;
    base_r     <= base_nxt;
    ptr_r      <= ptr_nxt;
    out_r      <= out_nxt;
  end

  // error result is always a lone final result
  `SDTCW_ASSERT(a_err_is_last, !(out_valid_r && out_r.out_of_range) || out_r.last, "error result without last")
  // a taken request goes straight to conversion or to its error result
  `SDTCW_ASSERT_NEXT(a_fire_start, in_fire, (state_r == sdtcw_pkg::ST_CONV || state_r == sdtcw_pkg::ST_ERROR), "request not started")
  // written characters are digits or the minus sign
  `SDTCW_ASSERT(a_char_ok, !(out_valid_r && !out_r.out_of_range) || (out_r.char_code >= sdtcw_pkg::ASCII_ZERO && out_r.char_code <= 8'h39) || out_r.char_code == sdtcw_pkg::ASCII_MINUS, "bad character code")
  // digit emission never runs with an empty digit count
  `SDTCW_ASSERT(a_digits_left, state_r != sdtcw_pkg::ST_DIGIT || dig_left_r != '0, "digit state with no digits left")

endmodule
